// ===== src/rig_pkg.sv =====
// rig_pkg: shared types for the reverse-in-groups block
// sequencer state codes and the tag carried beside the memory read data
`timescale 1ns / 1ps

package rig_pkg;

  typedef enum logic {
    S_FILL,
    S_DRAIN
  } state_t;

  // side information for the item held in the memory read register
  typedef struct packed {
    logic valid;
    logic run_last;
    logic list_done;
  } rig_tag_t;

endpackage

// ===== src/rig_mem.sv =====
// rig_mem: group buffer, one write port and one registered read port
// no package dependency
`timescale 1ns / 1ps

module rig_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read register holds its value while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/rig_seq.sv =====
// rig_seq: fill counter, group size register and drain sequencer
// uses rig_pkg for the state enum and the read tag struct
`timescale 1ns / 1ps

module rig_seq
  import rig_pkg::*;
#(
  parameter int MAX_GROUP = 16,
  parameter int AW        = 4,
  parameter int CW        = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [4:0]    cfg_data,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          end_of_list,
  input  logic          advance,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic          mem_re,
  output logic [AW-1:0] mem_raddr,
  output rig_tag_t      tag
);

  localparam int KW = (CW > 5) ? CW : 5;

  state_t        state, state_next;
  logic [4:0]    group_size;
  logic [AW-1:0] fill, fill_next;
  logic [CW-1:0] rem, rem_next;
  logic [AW-1:0] ptr, ptr_next;
  logic          reverse, reverse_next;
  logic          eol_flag, eol_flag_next;
  rig_tag_t      tag_next;

  logic [KW-1:0] k;
  logic [CW-1:0] n;
  logic          accept;
  logic          issue;

  // effective group size: zero acts as one, large values saturate
  always_comb begin
    if (group_size == 5'd0) begin
      k = KW'(1);
    end else if (KW'(group_size) > KW'(MAX_GROUP)) begin
      k = KW'(MAX_GROUP);
    end else begin
      k = KW'(group_size);
    end
  end

  assign n        = CW'(fill) + CW'(1);
  assign in_stall = (state != S_FILL);
  assign accept   = in_valid && !in_stall;
  assign issue    = (state == S_DRAIN) && advance && (rem != '0);

  assign mem_we    = accept;
  assign mem_waddr = fill;
  assign mem_re    = issue;
  assign mem_raddr = ptr;

  always_comb begin
    state_next    = state;
    fill_next     = fill;
    rem_next      = rem;
    ptr_next      = ptr;
    reverse_next  = reverse;
    eol_flag_next = eol_flag;
    tag_next      = tag;
    unique case (state)
      S_FILL: begin
        if (accept) begin
          if (KW'(n) >= k || end_of_list) begin
            state_next    = S_DRAIN;
            fill_next     = '0;
            rem_next      = n;
            reverse_next  = (KW'(n) >= k);
            eol_flag_next = end_of_list;
            ptr_next      = (KW'(n) >= k) ? fill : '0;
          end else begin
            fill_next = fill + AW'(1);
          end
        end
      end
      S_DRAIN: begin
        if (issue) begin
          rem_next = rem - CW'(1);
          ptr_next = reverse ? (ptr - AW'(1)) : (ptr + AW'(1));
          if (rem == CW'(1)) begin
            state_next = S_FILL;
          end
        end
      end
      default: begin
        state_next = S_FILL;
      end
    endcase
    // the read stage moves whenever the output register can take it
    if (advance) begin
      tag_next.valid     = issue;
      tag_next.run_last  = issue && (rem == CW'(1));
      tag_next.list_done = issue && (rem == CW'(1)) && eol_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_FILL;
      fill       <= '0;
      rem        <= '0;
      tag        <= '0;
      group_size <= 5'd2;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      rem   <= rem_next;
      tag   <= tag_next;
      if (cfg_we) begin
        group_size <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr      <= ptr_next;
    reverse  <= reverse_next;
    eol_flag <= eol_flag_next;
  end

endmodule

// ===== src/rig_out.sv =====
// rig_out: output register of the result channel
// uses rig_pkg for the read tag struct
`timescale 1ns / 1ps

module rig_out
  import rig_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  rig_tag_t    tag,
  input  logic [31:0] rdata,
  output logic        advance,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_value,
  output logic        run_last,
  output logic        list_done
);

  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_value <= rdata;
      run_last  <= tag.run_last;
      list_done <= tag.list_done;
    end
  end

endmodule

// ===== src/reverse_in_groups_of_k_unit.sv =====
// reverse_in_groups_of_k_unit: top level, reverses a list in groups
// instantiates rig_seq, rig_mem and rig_out; uses rig_pkg
//
// Usage
//   Input channel (in_valid / in_stall): one signed 32-bit value per item,
//   end_of_list on the final element. Output channel (out_valid /
//   out_stall): out_value, run_last on the last item of a run, list_done
//   on the last item of the list. cfg_we / cfg_data write group_size.
//   Values are stored one per cycle into the group buffer while in_stall
//   is low. When a group of group_size fills, or the list ends, the
//   buffered run is read back, reversed for a full group and in order
//   for a partial one. The first result of a run passes through the
//   sequencer, the memory read register and the output register after
//   the item that completes it is accepted; the remaining results follow
//   one per cycle while the receiver does not stall. A run is filled and
//   then read out before the next run is taken; in_stall is high while
//   the run is being read out.
//   A stalled receiver freezes the read stage and the output register.
//   Reset clears the fill count and the pipeline and sets group_size to 2.
`timescale 1ns / 1ps

module reverse_in_groups_of_k_unit
  import rig_pkg::*;
#(
  parameter int MAX_GROUP = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] value,
  input  logic               end_of_list,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_value,
  output logic               run_last,
  output logic               list_done
);

  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CW = $clog2(MAX_GROUP + 1);

  logic          advance;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   rdata;
  logic [31:0]   out_bits;
  rig_tag_t      tag;

  rig_seq #(
    .MAX_GROUP (MAX_GROUP),
    .AW        (AW),
    .CW        (CW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .end_of_list (end_of_list),
    .advance     (advance),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .tag         (tag)
  );

  rig_mem #(
    .DEPTH (MAX_GROUP),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (value),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  rig_out u_out (
    .clk       (clk),
    .rst       (rst),
    .tag       (tag),
    .rdata     (rdata),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_bits),
    .run_last  (run_last),
    .list_done (list_done)
  );

  assign out_value = signed'(out_bits);

endmodule

// ===== src/rig_checker.sv =====
// rig_checker: port-level assertions for reverse_in_groups_of_k_unit
// attached to the top level by the bind statement at the end of the file
`timescale 1ns / 1ps

module rig_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               end_of_list,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_value,
  input logic               run_last,
  input logic               list_done
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_value)
      && $stable(run_last) && $stable(list_done))
    else $error("stalled result item changed");

  // the end of the list always closes a run
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && list_done |-> run_last)
    else $error("list_done without run_last");

  // the final element always starts a readout, so input stalls next
  a_eol_drain: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && end_of_list |=> in_stall)
    else $error("no readout after end of list");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result item valid after reset");

endmodule

bind reverse_in_groups_of_k_unit rig_checker u_chk (.*);
